@@ rtl/swm_pkg.sv @@
// swm_pkg: shared constants and types for the sliding window maximum block
// no dependencies; used by swm_cell, swm_front_sel and sliding_window_maximum
`default_nettype none

package swm_pkg;

  // default sizing, handed to the top level parameters
  localparam int WindowMaxDef  = 16;
  localparam int SampleBitsDef = 16;

  // window length register
  localparam int          WlenW     = 5;
  localparam logic [4:0]  WlenReset = 5'd3;

  // per-beat control broadcast to every cell of the chain
  typedef struct packed {
    logic shift;  // a sample beat is taken this cycle
    logic clear;  // the beat starts a new sequence
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/swm_cell.sv @@
// swm_cell: one candidate slot of the chain, slot POS holds the sample of age POS
// depends on swm_pkg (cell_ctrl_t)
`default_nettype none

module swm_cell #(
  parameter int SAMPLE_BITS = swm_pkg::SampleBitsDef,
  parameter int LEN_W       = 5,
  parameter int POS         = 0
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire  swm_pkg::cell_ctrl_t ctrl_i,
  input  wire  [LEN_W-1:0]       len_i,
  input  wire  [SAMPLE_BITS-1:0] sample_i,
  input  wire  [SAMPLE_BITS-1:0] prev_value_i,
  input  wire                    prev_valid_i,
  output logic [SAMPLE_BITS-1:0] value_o,
  output logic                   valid_o
);

  localparam bit IsHead = (POS == 0);

  logic [SAMPLE_BITS-1:0] value_q;
  logic                   valid_q, valid_d;
  logic                   in_win, beaten, cleared;

  // candidate arriving from the younger neighbor is removed by a larger new sample
  assign beaten  = $signed(prev_value_i) < $signed(sample_i);
  assign in_win  = int'(len_i) > POS;
  assign cleared = ctrl_i.clear && !IsHead;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      valid_d = prev_valid_i && in_win && !beaten && !cleared;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      value_q <= prev_value_i;
    end
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

@@ rtl/swm_front_sel.sv @@
// swm_front_sel: picks the value of the oldest valid cell, which is the window maximum
// depends on swm_pkg for parameter defaults; fed from the swm_cell chain
`default_nettype none

module swm_front_sel #(
  parameter int SAMPLE_BITS = swm_pkg::SampleBitsDef,
  parameter int DEPTH       = swm_pkg::WindowMaxDef
) (
  input  wire  [DEPTH-1:0][SAMPLE_BITS-1:0] value_i,
  input  wire  [DEPTH-1:0]                  valid_i,
  output logic [SAMPLE_BITS-1:0]            value_o
);

  logic [DEPTH-1:0] hit;

  // one-hot on the highest valid index, then an and-or mux
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      hit[k] = valid_i[k] && ((valid_i >> (k + 1)) == '0);
    end
  end

  always_comb begin
    value_o = '0;
    for (int k = 0; k < DEPTH; k++) begin
      value_o = value_o | (value_i[k] & {SAMPLE_BITS{hit[k]}});
    end
  end

endmodule

`default_nettype wire

@@ rtl/sliding_window_maximum.sv @@
// sliding_window_maximum: top level, cell chain, sequence counter and result register
// depends on swm_pkg, swm_cell, swm_front_sel
//
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata: sample; tuser: start_req
// m_axis    out  m_axis_tvalid/tready        tdata: window_max
// cfg       in   cfg_valid_i/cfg_ready_o     cfg_data_i: window_len
//
// one sample beat per cycle while s_axis_tready is high; its result reaches m_axis
// through the cell chain update, then front select into the output register
// rst_ni clears the valid bits, the sequence count, window_len to 3 and both stages
// a stalled result holds in the output register; s_axis keeps taking beats while the
// pending stage is empty or can move, so a stall on m_axis backs up after one more result
`default_nettype none

module sliding_window_maximum #(
  parameter int WINDOW_MAX  = swm_pkg::WindowMaxDef,
  parameter int SAMPLE_BITS = swm_pkg::SampleBitsDef,
  localparam int DataW      = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // sample stream
  input  wire                      s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire  [DataW-1:0]         s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
  input  wire                      s_axis_tuser,   // [0] start_req
  // result stream
  output logic                     m_axis_tvalid,
  input  wire                      m_axis_tready,
  output logic [DataW-1:0]         m_axis_tdata,   // [SAMPLE_BITS-1:0] window_max
  // window length register
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire  [swm_pkg::WlenW-1:0] cfg_data_i
);

  localparam int CntW = $clog2(WINDOW_MAX + 1);

  logic [swm_pkg::WlenW-1:0] window_len_q;
  logic [CntW-1:0]           len_eff;
  logic [CntW-1:0]           seen_q, seen_d;
  logic                      pend_q, pend_d;
  logic                      out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]    out_data_q;
  logic                      in_beat, out_free, out_load;
  logic [SAMPLE_BITS-1:0]    sample;
  logic [SAMPLE_BITS-1:0]    front_value;
  swm_pkg::cell_ctrl_t       ctrl;

  logic [WINDOW_MAX-1:0][SAMPLE_BITS-1:0] cell_value;
  logic [WINDOW_MAX-1:0]                  cell_valid;

  assign cfg_ready_o = 1'b1;
  assign sample      = s_axis_tdata[SAMPLE_BITS-1:0];

  // clamp the register to 1..WINDOW_MAX
  always_comb begin
    if (window_len_q == '0) begin
      len_eff = CntW'(1);
    end else if (int'(window_len_q) > WINDOW_MAX) begin
      len_eff = CntW'(WINDOW_MAX);
    end else begin
      len_eff = CntW'(window_len_q);
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = pend_q && out_free;
  assign s_axis_tready = !pend_q || out_free;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  assign ctrl.shift = in_beat;
  assign ctrl.clear = s_axis_tuser;

  // cell chain, cell 0 takes the new sample, each cell hands its slot to the next
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    logic [SAMPLE_BITS-1:0] prev_value;
    logic                   prev_valid;
    if (k == 0) begin : g_head
      assign prev_value = sample;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_value = cell_value[k-1];
      assign prev_valid = cell_valid[k-1];
    end
    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LEN_W       (CntW),
      .POS         (k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .len_i        (len_eff),
      .sample_i     (sample),
      .prev_value_i (prev_value),
      .prev_valid_i (prev_valid),
      .value_o      (cell_value[k]),
      .valid_o      (cell_valid[k])
    );
  end

  swm_front_sel #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DEPTH       (WINDOW_MAX)
  ) u_front_sel (
    .value_i (cell_value),
    .valid_i (cell_valid),
    .value_o (front_value)
  );

  always_comb begin
    seen_d = seen_q;
    pend_d = pend_q;
    if (out_load) begin
      pend_d = 1'b0;
    end
    if (in_beat) begin
      if (s_axis_tuser) begin
        seen_d = CntW'(1);
      end else if (int'(seen_q) < WINDOW_MAX) begin
        seen_d = seen_q + CntW'(1);
      end
      pend_d = (seen_d >= len_eff);
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= swm_pkg::WlenReset;
      seen_q       <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        window_len_q <= cfg_data_i;
      end
      seen_q      <= seen_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= front_value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DataW'(out_data_q);

`ifndef SYNTHESIS
  // the newest sample is always a candidate after a beat
  a_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> cell_valid[0])
    else $error("head cell not valid after a sample beat");

  // a pending result always has a candidate to select
  a_pend_has_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (cell_valid != '0))
    else $error("result pending with an empty chain");

  a_seen_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(seen_q) <= WINDOW_MAX)
    else $error("sequence count beyond window depth");

  // candidates never decrease toward the old end of the chain
  for (genvar k = 0; k < WINDOW_MAX - 1; k++) begin : g_mono
    a_monotone : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cell_valid[k] && cell_valid[k+1]) |->
        ($signed(cell_value[k+1]) >= $signed(cell_value[k])))
      else $error("candidate order broken");
  end
`endif

endmodule

`default_nettype wire
